// ----- rtl/ccoal_pkg.sv -----
// Shared constants for the cache line request coalescer.
package ccoal_pkg;

  // Number of vertex id lanes carried by one input word.
  localparam int unsigned LANES = 16;

  // Width of one vertex id.
  localparam int unsigned ID_W = 32;

  // Width of a cache line index.
  localparam int unsigned LINE_W = 28;

  // Width of the burst_log register.
  localparam int unsigned CFG_W = 5;

  // Width of the total shift amount (burst_log plus the fixed base).
  localparam int unsigned SHAMT_W = 6;

  // Fixed part of the id to line shift.
  localparam int unsigned LINE_SHIFT_BASE = 4;

  // Value of burst_log after reset.
  localparam logic [CFG_W-1:0] BURST_LOG_RESET = CFG_W'(2);

  // Output tdata width: the line index padded to whole bytes.
  localparam int unsigned OUT_DATA_W = ((LINE_W + 7) / 8) * 8;

endpackage

// ----- rtl/ccoal_lane.sv -----
// One lane: turns a vertex id into a line index and flags a change from its left neighbor.
module ccoal_lane (
  input  logic [ccoal_pkg::ID_W-1:0]    id_i,
  input  logic [ccoal_pkg::SHAMT_W-1:0] shamt_i,
  input  logic [ccoal_pkg::LINE_W-1:0]  ref_line_i,
  input  logic                          ref_valid_i,
  output logic [ccoal_pkg::LINE_W-1:0]  line_o,
  output logic                          keep_o
);
  import ccoal_pkg::*;

  logic [ID_W-1:0] shifted;

  // Shifts of 32 or more clear the id, which gives line index zero.
  assign shifted = id_i >> shamt_i;
  assign line_o  = shifted[LINE_W-1:0];

  // A line is kept when there is nothing to compare with or it differs from the reference.
  assign keep_o = !ref_valid_i || (line_o != ref_line_i);

endmodule

// ----- rtl/ccoal_merge.sv -----
// Merging stage: holds the kept lines of one word and sends them out one per cycle unless the output stalls.
module ccoal_merge #(
  parameter int unsigned NumLanes = ccoal_pkg::LANES
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [NumLanes-1:0][ccoal_pkg::LINE_W-1:0] in_lines_i,
  input  logic [NumLanes-1:0]                       in_keep_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [ccoal_pkg::LINE_W-1:0]              out_line_o,
  output logic                                      out_last_o
);
  import ccoal_pkg::*;

  logic [NumLanes-1:0][LINE_W-1:0] lines_q;
  logic [NumLanes-1:0]             mask_q;
  logic [NumLanes-1:0]             mask_d;
  logic [NumLanes-1:0]             low_bit;
  logic [NumLanes-1:0]             mask_rem;
  logic [LINE_W-1:0]               sel_line;
  logic                            slot_free;
  logic                            pop;
  logic                            load;
  logic                            out_valid_q;
  logic [LINE_W-1:0]               out_line_q;
  logic                            out_last_q;

  // Lowest pending lane comes out first, which keeps lane order.
  assign low_bit  = mask_q & (~mask_q + NumLanes'(1));
  assign mask_rem = mask_q & ~low_bit;

  // One-hot selection of the pending line.
  always_comb begin
    sel_line = '0;
    for (int i = 0; i < NumLanes; i++) begin
      sel_line = sel_line | ({LINE_W{low_bit[i]}} & lines_q[i]);
    end
  end

  // A line moves to the output register whenever that register is empty or drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pop        = (mask_q != '0) && slot_free;
  assign in_ready_o = (mask_q == '0) || (pop && (mask_rem == '0));
  assign load       = in_valid_i && in_ready_o;

  // Pending mask update.
  always_comb begin
    mask_d = mask_q;
    if (pop) begin
      mask_d = mask_rem;
    end
    if (load) begin
      mask_d = in_keep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Line buffer of the word under way.
  always_ff @(posedge clk_i) begin
    if (load) begin
      lines_q <= in_lines_i;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; the last pending line closes the word.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_line_q <= sel_line;
      out_last_q <= (mask_rem == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_line_o  = out_line_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/cache_line_request_coalescer_top.sv -----
// Top level of the cache line request coalescer: lanes, history state and merging stage.
//
// Each input word carries NumLanes 32-bit vertex ids; each id is shifted right by
// burst_log + 4 into a cache line index, and in lane order only indices that differ
// from the last one sent are put out, with tlast on the final index of the word.
// A word with several indices to send holds the merging stage until each has moved on,
// since the output port carries one index per cycle; words that yield at most one index
// are taken every cycle unless the output stalls. The first index of a word passes the
// pending mask and line buffer, then the output register. All lanes are compared in
// parallel on accept, so a word is taken as the last index of the one before moves on.
module cache_line_request_coalescer_top #(
  parameter int unsigned NumLanes = ccoal_pkg::LANES
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Configuration: burst_log.
  input  logic                                        cfg_we_i,
  input  logic [ccoal_pkg::CFG_W-1:0]                 cfg_wdata_i,
  // Input stream.
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // tdata fields, low bits up: vertex_pair_0 .. vertex_pair_15 (lane 0 in bits 31..0).
  input  logic [NumLanes*ccoal_pkg::ID_W-1:0]         s_axis_tdata_i,
  // Output stream.
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // tdata fields, low bits up: line_index (28 bits), zero padding (4 bits).
  output logic [ccoal_pkg::OUT_DATA_W-1:0]            m_axis_tdata_o,
  // tlast: end_of_item.
  output logic                                        m_axis_tlast_o
);
  import ccoal_pkg::*;

  logic [CFG_W-1:0]                burst_log_q;
  logic [SHAMT_W-1:0]              shamt;
  logic [LINE_W-1:0]               prev_line_q;
  logic                            prev_valid_q;
  logic [NumLanes-1:0][LINE_W-1:0] lines;
  logic [NumLanes-1:0][LINE_W-1:0] ref_lines;
  logic [NumLanes-1:0]             ref_valid;
  logic [NumLanes-1:0]             keep;
  logic                            in_accept;
  logic [LINE_W-1:0]               out_line;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_log_q <= BURST_LOG_RESET;
    end else if (cfg_we_i) begin
      burst_log_q <= cfg_wdata_i;
    end
  end

  assign shamt = {1'b0, burst_log_q} + SHAMT_W'(LINE_SHIFT_BASE);

  // Lane 0 compares with the last line sent, every other lane with its left neighbor.
  always_comb begin
    ref_lines[0] = prev_line_q;
    ref_valid[0] = prev_valid_q;
    for (int i = 1; i < NumLanes; i++) begin
      ref_lines[i] = lines[i-1];
      ref_valid[i] = 1'b1;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    ccoal_lane u_lane (
      .id_i        (s_axis_tdata_i[g*ID_W +: ID_W]),
      .shamt_i     (shamt),
      .ref_line_i  (ref_lines[g]),
      .ref_valid_i (ref_valid[g]),
      .line_o      (lines[g]),
      .keep_o      (keep[g])
    );
  end

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // After any word the last line sent equals the line of its highest lane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_line_q  <= '0;
      prev_valid_q <= 1'b0;
    end else if (in_accept) begin
      prev_line_q  <= lines[NumLanes-1];
      prev_valid_q <= 1'b1;
    end
  end

  ccoal_merge #(
    .NumLanes (NumLanes)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_lines_i  (lines),
    .in_keep_i   (keep),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_line_o  (out_line),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(out_line);

endmodule

// ----- bench/cache_line_request_coalescer_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the cache line request coalescer top level.
module cache_line_request_coalescer_top_test;
  import ccoal_pkg::*;

  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned PHASE_WORDS      = 65;
  localparam int unsigned FLOOD_WORDS      = 40;

  // One input word: lane 0 sits in the lowest 32 bits.
  typedef logic [LANES-1:0][ID_W-1:0] vertex_word_t;

  // One expected output word.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              end_of_item;
  } line_req_t;

  // How the generator derives a lane id from the previous lane.
  typedef enum int unsigned {
    LANE_REPEAT,
    LANE_SAME_LINE,
    LANE_NEXT_LINE,
    LANE_FRESH
  } lane_pick_e;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  vertex_word_t          s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  // Predictor state: register copy and the coalescing history.
  logic [CFG_W-1:0]  burst_log_q  = BURST_LOG_RESET;
  logic [LINE_W-1:0] last_line_q  = '0;
  logic              last_valid_q = 1'b0;
  line_req_t         pending_lines[$];

  // Generator and idling controls.
  logic [ID_W-1:0] gen_last_id    = '0;
  int unsigned     tx_idle_max    = 4;
  int unsigned     rx_idle_max    = 4;
  int unsigned     rx_hold_cycles = 0;

  // Run statistics.
  int unsigned words_sent    = 0;
  int unsigned lines_checked = 0;
  int unsigned silent_words  = 0;
  int unsigned mismatches    = 0;
  logic [31:0] burst_logs_written = '0;

  cache_line_request_coalescer_top #(
    .NumLanes(LANES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // 100 MHz clock.
  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Current total shift from id to line index.
  function automatic logic [SHAMT_W-1:0] line_shift();
    return SHAMT_W'(burst_log_q) + SHAMT_W'(LINE_SHIFT_BASE);
  endfunction

  // Queue the line words that an accepted input word produces.
  function automatic void predict_lines(vertex_word_t word);
    logic [SHAMT_W-1:0] shamt;
    logic [63:0]        wide_id;
    logic [LINE_W-1:0]  line;
    line_req_t          produced[$];
    shamt = line_shift();
    for (int lane = 0; lane < LANES; lane++) begin
      wide_id = 64'(word[lane]);
      line = LINE_W'(wide_id >> shamt);
      if (!last_valid_q || line != last_line_q) begin
        produced.push_back('{line: line, end_of_item: 1'b0});
        last_line_q  = line;
        last_valid_q = 1'b1;
      end
    end
    if (produced.size() == 0) begin
      silent_words++;
    end else begin
      produced[produced.size()-1].end_of_item = 1'b1;
      foreach (produced[k]) pending_lines.push_back(produced[k]);
    end
  endfunction

  // Compare one output word with the oldest expected line.
  function automatic void check_line(logic [LINE_W-1:0] line, logic last);
    line_req_t want;
    lines_checked++;
    if (pending_lines.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("unexpected line word: line %h last %b", line, last);
      end
      return;
    end
    want = pending_lines.pop_front();
    if (line !== want.line || last !== want.end_of_item) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("line word %0d: expected line %h last %b, got line %h last %b",
                 lines_checked, want.line, want.end_of_item, line, last);
      end
    end
  endfunction

  // Random word built from runs of repeats, same-line ids, neighbor lines and noise.
  function automatic vertex_word_t random_word();
    vertex_word_t word;
    logic [63:0]  line_span;
    logic [ID_W-1:0] prev;
    int unsigned  style;
    lane_pick_e   pick;
    line_span = 64'd1 << line_shift();
    prev  = gen_last_id;
    style = $urandom_range(0, 9);
    for (int lane = 0; lane < LANES; lane++) begin
      // Style zero repeats the previous line everywhere; style one is pure noise.
      if (style == 0) begin
        pick = LANE_REPEAT;
      end else if (style == 1) begin
        pick = LANE_FRESH;
      end else begin
        pick = lane_pick_e'($urandom_range(0, 3));
      end
      case (pick)
        LANE_REPEAT:    word[lane] = prev;
        LANE_SAME_LINE: word[lane] = prev ^ ID_W'($urandom() & (line_span - 64'd1));
        LANE_NEXT_LINE: word[lane] = prev + ID_W'(line_span);
        default:        word[lane] = $urandom();
      endcase
      prev = word[lane];
    end
    gen_last_id = prev;
    return word;
  endfunction

  // Offer one input word after a random gap and predict it once accepted.
  task automatic send_word(vertex_word_t word);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_lines(word);
    gen_last_id = word[LANES-1];
    words_sent++;
  endtask

  // Stop offering, wait for every expected line, then let the pipeline settle.
  task automatic drain_and_settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write burst_log while the block is idle.
  task automatic write_burst_log(logic [CFG_W-1:0] value);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    burst_log_q = value;
    burst_logs_written[value] = 1'b1;
  endtask

  // Reset shift: first line is always sent, repeats are dropped, lines step by one.
  task automatic test_reset_shift();
    vertex_word_t word;
    logic [SHAMT_W-1:0] shamt;
    shamt = line_shift();
    // Line zero right after reset must still be sent.
    send_word('0);
    // Nothing new: all zeros again, then ids that stay inside line zero.
    send_word('0);
    send_word({LANES{ID_W'((64'd1 << shamt) - 64'd1)}});
    for (int lane = 0; lane < LANES; lane++) word[lane] = ID_W'(lane) << shamt;
    send_word(word);
    send_word({LANES{32'hFFFF_FFFF}});
    for (int lane = 0; lane < LANES; lane++) word[lane] = (lane % 2 == 0) ? '0 : '1;
    send_word(word);
    // Pairs of lanes share a line with different offsets.
    for (int lane = 0; lane < LANES; lane++) begin
      word[lane] = (ID_W'(lane / 2 + 1) << shamt) | ($urandom() & ((32'd1 << shamt) - 1));
    end
    send_word(word);
  endtask

  // Extreme burst_log values, including those that shift every id to zero.
  task automatic test_shift_extremes();
    vertex_word_t word;
    write_burst_log(CFG_W'(0));
    send_word({LANES{32'hFFFF_FFFF}});
    for (int lane = 0; lane < LANES; lane++) word[lane] = ID_W'(lane) << 4;
    send_word(word);
    for (int lane = 0; lane < LANES; lane++) word[lane] = 32'h0000_00F0 | ID_W'(lane % 16);
    send_word(word);
    write_burst_log(CFG_W'(27));
    for (int lane = 0; lane < LANES; lane++) begin
      word[lane] = (lane % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    send_word(word);
    send_word({LANES{32'hFFFF_FFFF}});
    // Shifts of 32 and beyond map every id to line zero.
    write_burst_log(CFG_W'(28));
    for (int lane = 0; lane < LANES; lane++) word[lane] = $urandom();
    send_word(word);
    send_word({LANES{32'hFFFF_FFFF}});
    write_burst_log(CFG_W'(31));
    for (int lane = 0; lane < LANES; lane++) word[lane] = $urandom();
    send_word(word);
    write_burst_log(BURST_LOG_RESET);
    send_word({LANES{32'hA5A5_A5A5}});
  endtask

  // Random phases over several shifts and idling mixes.
  task automatic test_random_phases();
    logic [CFG_W-1:0] setting;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       setting = CFG_W'(0);
        1:       setting = CFG_W'(27);
        2:       setting = CFG_W'($urandom_range(29, 31));
        default: setting = CFG_W'($urandom_range(0, 27));
      endcase
      write_burst_log(setting);
      // Odd phases run without idling on one or both sides.
      tx_idle_max = (phase % 2 == 1) ? 0 : 4;
      rx_idle_max = (phase == 3) ? 0 : 4;
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
    end
    tx_idle_max = 4;
    rx_idle_max = 4;
  endtask

  // The receiver holds off while the sender keeps offering distinct lines.
  task automatic test_output_backpressure();
    vertex_word_t word;
    write_burst_log(CFG_W'(0));
    tx_idle_max    = 0;
    rx_hold_cycles = LONG_HOLD_CYCLES;
    for (int n = 0; n < FLOOD_WORDS; n++) begin
      for (int lane = 0; lane < LANES; lane++) word[lane] = $urandom();
      send_word(word);
    end
    tx_idle_max = 4;
  endtask

  // Result sink: random ready gaps, one long hold on request, check per word.
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_idle_max);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_line(m_axis_tdata_o[LINE_W-1:0], m_axis_tlast_o);
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  initial begin : stall_watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no word moved for %0d cycles, %0d line words outstanding",
             STALL_LIMIT, pending_lines.size());
    $display("cache_line_request_coalescer_top_test failed");
    $finish;
  end

  // Test sequence.
  initial begin : test_sequence
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_shift();
    test_shift_extremes();
    test_random_phases();
    test_output_backpressure();
    drain_and_settle();
    $display("sent %0d input words (%0d produced no line), checked %0d line words",
             words_sent, silent_words, lines_checked);
    $display("burst_log settings written (bit per value): %b, mismatches: %0d",
             burst_logs_written, mismatches);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("cache_line_request_coalescer_top_test passed");
    end else begin
      $display("cache_line_request_coalescer_top_test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ccoal_pkg.sv
rtl/ccoal_lane.sv
rtl/ccoal_merge.sv
rtl/cache_line_request_coalescer_top.sv
bench/cache_line_request_coalescer_top_test.sv
